// ----- hw/rtl/encoder_dimmer_with_ramp_macros.svh -----
// ---------------------------------------------------------------------------
// encoder dimmer assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ENCODER_DIMMER_WITH_RAMP_MACROS_SVH
`define ENCODER_DIMMER_WITH_RAMP_MACROS_SVH

// same cycle implication
`define EDR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication
`define EDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/edr_pkg.sv -----
// ---------------------------------------------------------------------------
// edr_pkg
// shared types, register indexes and lookup tables of the encoder dimmer
// ---------------------------------------------------------------------------
package edr_pkg;

  localparam logic [2:0] REG_RAMP_PERIOD   = 3'd0;
  localparam logic [2:0] REG_FAST_WINDOW   = 3'd1;
  localparam logic [2:0] REG_MEDIUM_WINDOW = 3'd2;
  localparam logic [2:0] REG_SLOW_WINDOW   = 3'd3;
  localparam logic [2:0] REG_RAMP_CEILING  = 3'd4;

  localparam logic [7:0] RST_RAMP_PERIOD   = 8'd5;
  localparam logic [7:0] RST_FAST_WINDOW   = 8'd20;
  localparam logic [7:0] RST_MEDIUM_WINDOW = 8'd30;
  localparam logic [7:0] RST_SLOW_WINDOW   = 8'd40;
  localparam logic [7:0] RST_RAMP_CEILING  = 8'd254;
  localparam logic [7:0] RST_SINCE_DETENT  = 8'd255;

  localparam int ROM_SIZE = 188;

  typedef struct packed {
    logic [7:0] ramp_period;
    logic [7:0] fast_window;
    logic [7:0] medium_window;
    logic [7:0] slow_window;
    logic [7:0] ramp_ceiling;
  } cfg_t;

  typedef enum logic [1:0] {
    STEP_TEN  = 2'd0,
    STEP_FIVE = 2'd1,
    STEP_TWO  = 2'd2,
    STEP_ONE  = 2'd3
  } step_t;

  typedef struct packed {
    logic  tick;
    logic  detent;
    logic  down;
    step_t step;
  } item_t;

  localparam logic signed [3:0] STEP_TABLE [16] = '{
    4'sd0, -4'sd1, 4'sd1, 4'sd0, 4'sd1, 4'sd0, 4'sd0, -4'sd1,
    -4'sd1, 4'sd0, 4'sd0, 4'sd1, 4'sd0, 4'sd1, -4'sd1, 4'sd0
  };

  localparam logic [7:0] GAMMA_ROM [ROM_SIZE] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8,
    8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18,
    8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd25, 8'd26, 8'd27,
    8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd36,
    8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd45,
    8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
    8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd65,
    8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74, 8'd75,
    8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd84, 8'd85, 8'd86, 8'd87,
    8'd88, 8'd90, 8'd91, 8'd92, 8'd93, 8'd95, 8'd96, 8'd97, 8'd99, 8'd100,
    8'd101, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109, 8'd111, 8'd112, 8'd114,
    8'd115, 8'd117, 8'd118, 8'd119, 8'd121, 8'd122, 8'd124, 8'd125, 8'd127, 8'd128,
    8'd130, 8'd131, 8'd133, 8'd135, 8'd136, 8'd138, 8'd139, 8'd141, 8'd142, 8'd144,
    8'd146, 8'd147, 8'd149, 8'd151, 8'd152, 8'd154, 8'd156, 8'd157, 8'd159, 8'd161,
    8'd162, 8'd164, 8'd166, 8'd168, 8'd169, 8'd171, 8'd173, 8'd175, 8'd176, 8'd178,
    8'd180, 8'd182, 8'd184, 8'd186, 8'd187, 8'd189, 8'd191, 8'd193, 8'd195, 8'd197,
    8'd199, 8'd201, 8'd203, 8'd205, 8'd207, 8'd209, 8'd211, 8'd213, 8'd215, 8'd217,
    8'd219, 8'd221, 8'd223, 8'd225, 8'd227, 8'd229, 8'd231, 8'd233, 8'd235, 8'd237,
    8'd239, 8'd241, 8'd244, 8'd246, 8'd248, 8'd250, 8'd252, 8'd255
  };

  function automatic logic [7:0] gamma_lookup(logic [7:0] idx);
    logic [7:0] val;
    if ({1'b0, idx} < 9'(ROM_SIZE)) begin
      val = GAMMA_ROM[idx];
    end else begin
      val = 8'hff;
    end
    return val;
  endfunction

  function automatic logic [3:0] step_mag(step_t s);
    logic [3:0] m;
    unique case (s)
      STEP_TEN:  m = 4'd10;
      STEP_FIVE: m = 4'd5;
      STEP_TWO:  m = 4'd2;
      STEP_ONE:  m = 4'd1;
      default:   m = 4'd1;
    endcase
    return m;
  endfunction

endpackage

// ----- hw/rtl/edr_front.sv -----
// ---------------------------------------------------------------------------
// edr_front
// quadrature decode, detent detection and step size classification
// ---------------------------------------------------------------------------
module edr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  edr_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_encoder_pins,
  input  logic           in_tick,
  output logic           push_valid,
  input  logic           push_ready,
  output edr_pkg::item_t push_data
);

  logic [3:0]        pin_history_r, pin_history_nxt;
  logic signed [3:0] pulse_sum_r, pulse_sum_nxt;
  logic [7:0]        since_detent_r, since_detent_nxt;
  logic signed [3:0] sum_new;
  logic              detent;
  logic              fire;
  edr_pkg::step_t    step;

  assign fire       = in_valid && push_ready;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    pin_history_nxt = {pin_history_r[1:0], ~in_encoder_pins};
    sum_new         = pulse_sum_r + edr_pkg::STEP_TABLE[pin_history_nxt];
    detent          = (sum_new > 4'sd3) || (sum_new < -4'sd3);
    pulse_sum_nxt   = detent ? 4'sd0 : sum_new;

    priority if (since_detent_r < cfg.fast_window) begin
      step = edr_pkg::STEP_TEN;
    end else if (since_detent_r < cfg.medium_window) begin
      step = edr_pkg::STEP_FIVE;
    end else if (since_detent_r < cfg.slow_window) begin
      step = edr_pkg::STEP_TWO;
    end else begin
      step = edr_pkg::STEP_ONE;
    end

    // detent clears the count before this sample's tick
    if (detent) begin
      since_detent_nxt = {7'd0, in_tick};
    end else if (in_tick && since_detent_r != 8'hff) begin
      since_detent_nxt = since_detent_r + 8'd1;
    end else begin
      since_detent_nxt = since_detent_r;
    end

    push_data.tick   = in_tick;
    push_data.detent = detent;
    push_data.down   = sum_new < 4'sd0;
    push_data.step   = step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_history_r  <= 4'd0;
      pulse_sum_r    <= 4'sd0;
      since_detent_r <= edr_pkg::RST_SINCE_DETENT;
    end else if (fire) begin
      pin_history_r  <= pin_history_nxt;
      pulse_sum_r    <= pulse_sum_nxt;
      since_detent_r <= since_detent_nxt;
    end
  end

endmodule

// ----- hw/rtl/edr_queue.sv -----
// ---------------------------------------------------------------------------
// edr_queue
// two-entry queue between the decode front and the ramp back
// ---------------------------------------------------------------------------
`include "encoder_dimmer_with_ramp_macros.svh"

module edr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  edr_pkg::item_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output edr_pkg::item_t pop_data
);

  edr_pkg::item_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push_fire, pop_fire;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push_fire ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_fire} - {1'b0, pop_fire};
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `EDR_ASSERT(a_cnt_range, 1'b1, count_r != 2'd3, "queue count out of range")
  `EDR_ASSERT(a_ptr_gap, count_r == 2'd0 || count_r == 2'd2, wr_ptr_r == rd_ptr_r, "ptrs")
  `EDR_ASSERT_NEXT(a_cnt_inc, push_fire && !pop_fire, count_r == $past(count_r) + 2'd1, "inc")

endmodule

// ----- hw/rtl/edr_back.sv -----
// ---------------------------------------------------------------------------
// edr_back
// brightness index, gamma lookup, level ramp and result register
// ---------------------------------------------------------------------------
`include "encoder_dimmer_with_ramp_macros.svh"

module edr_back #(
  parameter int TABLE_ENTRIES = 188
) (
  input  logic           clk,
  input  logic           rst_n,
  input  edr_pkg::cfg_t  cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  edr_pkg::item_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_level,
  output logic           out_pwm_enable,
  output logic [7:0]     out_target_level,
  output logic           out_detent_taken
);

  localparam logic [7:0] LIMIT = 8'(TABLE_ENTRIES - 1);

  logic [7:0] bright_index_r, bright_index_nxt;
  logic [7:0] target_r, target_nxt;
  logic [7:0] current_r, current_nxt;
  logic [7:0] tick_phase_r, tick_phase_nxt;
  logic       out_valid_r;
  logic       out_pwm_r, out_detent_r;
  logic [3:0] mag;
  logic [8:0] up_sum;
  logic       fire;

  assign pop_ready        = !out_valid_r || out_ready;
  assign fire             = pop_valid && pop_ready;
  assign out_valid        = out_valid_r;
  assign out_level        = current_r;
  assign out_target_level = target_r;
  assign out_pwm_enable   = out_pwm_r;
  assign out_detent_taken = out_detent_r;

  always_comb begin
    mag    = edr_pkg::step_mag(pop_data.step);
    up_sum = {1'b0, bright_index_r} + {5'd0, mag};

    bright_index_nxt = bright_index_r;
    target_nxt       = target_r;
    if (pop_data.detent) begin
      if (pop_data.down) begin
        bright_index_nxt = ({4'd0, mag} > bright_index_r) ? 8'd0
                                                          : bright_index_r - {4'd0, mag};
      end else begin
        bright_index_nxt = (up_sum > {1'b0, LIMIT}) ? LIMIT : up_sum[7:0];
      end
      target_nxt = edr_pkg::gamma_lookup(bright_index_nxt);
    end

    current_nxt    = current_r;
    tick_phase_nxt = tick_phase_r;
    if (pop_data.tick) begin
      if (tick_phase_r == 8'd0) begin
        priority if (target_nxt > current_r && current_r < cfg.ramp_ceiling) begin
          current_nxt = current_r + 8'd1;
        end else if (target_nxt < current_r && current_r != 8'd0) begin
          current_nxt = current_r - 8'd1;
        end
      end
      // period below phase wraps at once
      if ({1'b0, tick_phase_r} + 9'd1 >= {1'b0, cfg.ramp_period}) begin
        tick_phase_nxt = 8'd0;
      end else begin
        tick_phase_nxt = tick_phase_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_index_r <= 8'd0;
      target_r       <= 8'd0;
      current_r      <= 8'd0;
      tick_phase_r   <= 8'd0;
      out_valid_r    <= 1'b0;
      out_pwm_r      <= 1'b0;
      out_detent_r   <= 1'b0;
    end else begin
      if (fire) begin
        bright_index_r <= bright_index_nxt;
        target_r       <= target_nxt;
        current_r      <= current_nxt;
        tick_phase_r   <= tick_phase_nxt;
        out_pwm_r      <= current_nxt != 8'd0;
        out_detent_r   <= pop_data.detent;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  `EDR_ASSERT(a_index_range, 1'b1, bright_index_r <= LIMIT, "index beyond table")
  `EDR_ASSERT(a_pwm_flag, out_valid_r, out_pwm_r == (current_r != 8'd0), "pwm flag mismatch")
  `EDR_ASSERT_NEXT(a_hold_stall, out_valid_r && !out_ready, $stable(current_r), "level moved")
  `EDR_ASSERT_NEXT(a_level_slew, 1'b1, 8'(current_r - $past(current_r) + 8'd1) <= 8'd2, "slew")

endmodule

// ----- hw/rtl/encoder_dimmer_with_ramp.sv -----
// ---------------------------------------------------------------------------
// encoder_dimmer_with_ramp
// rotary encoder led dimmer with gamma table and slew limited level ramp
// ---------------------------------------------------------------------------
// in_* carries one sample of the active low encoder pins and a 1 ms tick per
// transfer; out_* returns one result per sample: level, pwm enable, target
// level and a detent flag. cfg_we/cfg_index/cfg_wdata writes the ramp period,
// the three speed windows and the ramp ceiling; write only while idle.
// one sample is taken every cycle while in_ready is high: the decode front
// updates its state and pushes a classified step into a two-entry queue, the
// back applies it to the index, gamma table and ramp and registers the
// result. out_valid rises once the step has passed the queue entry and the
// result register; throughput is one per cycle while out_ready is high.
// when the receiver stalls, the result register holds and the queue fills;
// in_ready falls once both queue entries are taken.
// reset clears all state, restores register defaults and empties the queue;
// in_ready is high in the first cycle after reset.
// ---------------------------------------------------------------------------
module encoder_dimmer_with_ramp #(
  parameter int TABLE_ENTRIES = 188
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_encoder_pins,
  input  logic       in_tick,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_level,
  output logic       out_pwm_enable,
  output logic [7:0] out_target_level,
  output logic       out_detent_taken
);

  edr_pkg::cfg_t  cfg_r;
  edr_pkg::item_t push_data, pop_data;
  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_period   <= edr_pkg::RST_RAMP_PERIOD;
      cfg_r.fast_window   <= edr_pkg::RST_FAST_WINDOW;
      cfg_r.medium_window <= edr_pkg::RST_MEDIUM_WINDOW;
      cfg_r.slow_window   <= edr_pkg::RST_SLOW_WINDOW;
      cfg_r.ramp_ceiling  <= edr_pkg::RST_RAMP_CEILING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        edr_pkg::REG_RAMP_PERIOD:   cfg_r.ramp_period   <= cfg_wdata;
        edr_pkg::REG_FAST_WINDOW:   cfg_r.fast_window   <= cfg_wdata;
        edr_pkg::REG_MEDIUM_WINDOW: cfg_r.medium_window <= cfg_wdata;
        edr_pkg::REG_SLOW_WINDOW:   cfg_r.slow_window   <= cfg_wdata;
        edr_pkg::REG_RAMP_CEILING:  cfg_r.ramp_ceiling  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  edr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_encoder_pins (in_encoder_pins),
    .in_tick         (in_tick),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  edr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  edr_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_level        (out_level),
    .out_pwm_enable   (out_pwm_enable),
    .out_target_level (out_target_level),
    .out_detent_taken (out_detent_taken)
  );

endmodule
